[sv/hbs_pkg.sv]
`timescale 1ns / 1ps

package hbs_pkg;

   localparam int MAP_DIM_DEFAULT = 256;

   localparam int POS_W    = 18;
   localparam int FRAC_W   = 8;
   localparam int CELL_W   = 8;
   localparam int SAMPLE_W = 8;
   localparam int SCALE_W  = 16;
   localparam int HEIGHT_W = 24;

   // Q8.8 unity scale
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   // Latency from accept edge to the edge that takes the result
   localparam int LATENCY = 4;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_SAMPLE = 1'b1
   } action_type;

endpackage

[sv/heightmap_bilinear_sample.sv]
`timescale 1ns / 1ps

// Heightmap bilinear sampler.
// Input channel: an item is taken at a rising edge with start high and busy low.
//   req_action = write stores req_cell_value at (req_cell_x, req_cell_z); no result.
//   req_action = sample takes the Q.8 position (req_pos_x, req_pos_z) and returns
//   the bilinearly blended height scaled by the Q8.8 register.
// Result channel: rsp_valid marks a result for exactly one cycle; the receiver
//   cannot stall, so rsp_height and rsp_outside_map must be taken when shown.
// Config channel: csr_wdata is written to the scale register at an edge with
//   csr_valid and csr_ready high; write it only while no item is in flight.
// Throughput: one item per cycle whenever busy is low. The map is split into four
//   banks by column and row parity, so the four corners of any cell land in
//   four different banks and each bank's single read port serves one corner.
// Pipeline: a result passes the memory read, row blend, column blend and
//   scale multiply registers in that order after its accept edge.
// A write commits at its accept edge, so a sample taken on the next cycle
//   already sees it.
// Reset: clears the pipeline and loads the scale with 1.0; busy is high
//   during reset and for the first cycle after it. Map contents are kept and
//   are undefined until written.
module heightmap_bilinear_sample #(
   parameter int MAP_DIM = hbs_pkg::MAP_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic signed [hbs_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [hbs_pkg::POS_W-1:0]    req_pos_z,
   input  logic [hbs_pkg::CELL_W-1:0]          req_cell_x,
   input  logic [hbs_pkg::CELL_W-1:0]          req_cell_z,
   input  logic [hbs_pkg::SAMPLE_W-1:0]        req_cell_value,
   output logic                                rsp_valid,
   output logic [hbs_pkg::HEIGHT_W-1:0]        rsp_height,
   output logic                                rsp_outside_map,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hbs_pkg::SCALE_W-1:0]         csr_wdata
);

   // Index width of one coordinate, and of one coordinate within a bank
   localparam int IW = (MAP_DIM > 1) ? $clog2(MAP_DIM) : 1;
   localparam int HW = (IW > 1) ? IW - 1 : 1;
   localparam int BANK_DEPTH = 2 ** (2 * HW);
   localparam int CIW = hbs_pkg::POS_W - 1 - hbs_pkg::FRAC_W;  // floored cell bits
   localparam int SW = hbs_pkg::SAMPLE_W;
   localparam int FW = hbs_pkg::FRAC_W;
   localparam int RW = SW + FW;          // row blend, Q8
   localparam int BW = hbs_pkg::HEIGHT_W; // column blend, Q16
   localparam int PW = BW + hbs_pkg::SCALE_W;

   logic accept;
   logic is_sample;
   logic is_write;

   logic busy_ff;
   logic [hbs_pkg::SCALE_W-1:0] scale_ff;

   // Sample address decode
   logic [CIW-1:0] cx_raw;
   logic [CIW-1:0] cz_raw;
   logic           in_range;
   logic [IW-1:0]  cx_idx;
   logic [IW-1:0]  cz_idx;
   logic [IW-1:0]  cx_next;
   logic [IW-1:0]  cz_next;

   // Write address decode
   logic          wr_ok;
   logic [IW-1:0] wx_idx;
   logic [IW-1:0] wz_idx;
   logic [1:0]    wr_bank;
   logic [2*HW-1:0] wr_addr;

   logic [2*HW-1:0] rd_addr [4];
   logic [SW-1:0]   bank_rd_ff [4];

   // Stage 1: read data returns
   logic          s1_valid_ff;
   logic          s1_outside_ff;
   logic [FW-1:0] s1_fx_ff;
   logic [FW-1:0] s1_fz_ff;
   logic          s1_px_ff;
   logic          s1_pz_ff;

   // Stage 2: row blends
   logic          s2_valid_ff;
   logic          s2_outside_ff;
   logic [FW-1:0] s2_fx_ff;
   logic [RW-1:0] row0_ff;
   logic [RW-1:0] row1_ff;
   logic [RW-1:0] row0_in;
   logic [RW-1:0] row1_in;

   // Stage 3: column blend
   logic          s3_valid_ff;
   logic          s3_outside_ff;
   logic [BW-1:0] blend_ff;
   logic [BW-1:0] blend_in;

   // Stage 4: scaled result
   logic                         rsp_valid_ff;
   logic                         rsp_outside_ff;
   logic [hbs_pkg::HEIGHT_W-1:0] rsp_height_ff;
   logic [hbs_pkg::HEIGHT_W-1:0] height_in;

   logic [SW-1:0]  h11, h12, h21, h22;
   logic [FW:0]    wfx, wfz;
   logic [PW-1:0]  scaled;

   assign accept    = start && !busy_ff;
   assign is_sample = req_action == hbs_pkg::ACT_SAMPLE;
   assign is_write  = req_action == hbs_pkg::ACT_WRITE;

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // Hold busy through reset and one cycle beyond
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= hbs_pkg::SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_wdata;
      end
   end

   // Floor each coordinate; the sign bit marks a negative position
   assign cx_raw   = req_pos_x[hbs_pkg::POS_W-2:FW];
   assign cz_raw   = req_pos_z[hbs_pkg::POS_W-2:FW];
   assign in_range = !req_pos_x[hbs_pkg::POS_W-1] && !req_pos_z[hbs_pkg::POS_W-1] &&
                     (32'(cx_raw) < 32'(MAP_DIM - 1)) &&
                     (32'(cz_raw) < 32'(MAP_DIM - 1));
   assign cx_idx   = IW'(cx_raw);
   assign cz_idx   = IW'(cz_raw);
   assign cx_next  = cx_idx + IW'(1);
   assign cz_next  = cz_idx + IW'(1);

   // Each bank gets the corner whose parity matches it
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         logic [IW-1:0] xs;
         logic [IW-1:0] zs;
         xs = (cx_idx[0] == b[1]) ? cx_idx : cx_next;
         zs = (cz_idx[0] == b[0]) ? cz_idx : cz_next;
         rd_addr[b] = {HW'(xs >> 1), HW'(zs >> 1)};
      end
   end

   assign wr_ok   = (32'(req_cell_x) < 32'(MAP_DIM)) && (32'(req_cell_z) < 32'(MAP_DIM));
   assign wx_idx  = IW'(req_cell_x);
   assign wz_idx  = IW'(req_cell_z);
   assign wr_bank = {wx_idx[0], wz_idx[0]};
   assign wr_addr = {HW'(wx_idx >> 1), HW'(wz_idx >> 1)};

   for (genvar gb = 0; gb < 4; gb++) begin : g_bank
      logic [SW-1:0] mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (accept && is_write && wr_ok && (wr_bank == 2'(gb))) begin
            mem[wr_addr] <= req_cell_value;
         end
         if (accept && is_sample) begin
            bank_rd_ff[gb] <= mem[rd_addr[gb]];
         end
      end
   end

   // Stage 1 control and fractions
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && is_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_sample) begin
         s1_outside_ff <= !in_range;
         s1_fx_ff      <= req_pos_x[FW-1:0];
         s1_fz_ff      <= req_pos_z[FW-1:0];
         s1_px_ff      <= cx_idx[0];
         s1_pz_ff      <= cz_idx[0];
      end
   end

   // Route banks back to corners
   assign h11 = bank_rd_ff[{s1_px_ff,  s1_pz_ff}];
   assign h12 = bank_rd_ff[{s1_px_ff, !s1_pz_ff}];
   assign h21 = bank_rd_ff[{!s1_px_ff,  s1_pz_ff}];
   assign h22 = bank_rd_ff[{!s1_px_ff, !s1_pz_ff}];

   assign wfz = (FW + 1)'(2 ** FW) - {1'b0, s1_fz_ff};
   assign row0_in = RW'((RW + 1)'(h11) * (RW + 1)'(wfz) + (RW + 1)'(h12) * (RW + 1)'(s1_fz_ff));
   assign row1_in = RW'((RW + 1)'(h21) * (RW + 1)'(wfz) + (RW + 1)'(h22) * (RW + 1)'(s1_fz_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_outside_ff <= s1_outside_ff;
         s2_fx_ff      <= s1_fx_ff;
         row0_ff       <= row0_in;
         row1_ff       <= row1_in;
      end
   end

   assign wfx = (FW + 1)'(2 ** FW) - {1'b0, s2_fx_ff};
   assign blend_in = BW'((BW + 1)'(row0_ff) * (BW + 1)'(wfx) +
                         (BW + 1)'(row1_ff) * (BW + 1)'(s2_fx_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_outside_ff <= s2_outside_ff;
         blend_ff      <= blend_in;
      end
   end

   // Scale by Q8.8 and drop 16 fraction bits; an outside position reads zero
   assign scaled    = PW'(blend_ff) * PW'(scale_ff);
   assign height_in = s3_outside_ff ? '0 : scaled[PW-1:hbs_pkg::SCALE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         rsp_outside_ff <= s3_outside_ff;
         rsp_height_ff  <= height_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_height      = rsp_height_ff;
   assign rsp_outside_map = rsp_outside_ff;

endmodule

[sv/hbs_checker.sv]
`timescale 1ns / 1ps

module hbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_action,
   input logic [hbs_pkg::POS_W-1:0]     req_pos_x,
   input logic                          rsp_valid,
   input logic [hbs_pkg::HEIGHT_W-1:0]  rsp_height,
   input logic                          rsp_outside_map
);

   logic acc_sample;
   logic acc_write;

   assign acc_sample = start && !busy && (req_action == hbs_pkg::ACT_SAMPLE);
   assign acc_write  = start && !busy && (req_action == hbs_pkg::ACT_WRITE);

   // Every sample item yields exactly one result at fixed latency
   a_sample_result: assert property (@(posedge clock) disable iff (reset)
      acc_sample |-> ##(hbs_pkg::LATENCY) rsp_valid)
      else $error("sample item produced no result");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      acc_write |-> ##(hbs_pkg::LATENCY) !rsp_valid)
      else $error("write item produced a result");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc_sample, hbs_pkg::LATENCY))
      else $error("result without a sample item");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside_map |-> rsp_height == '0)
      else $error("outside result carries a height");

   a_negative_outside: assert property (@(posedge clock) disable iff (reset)
      acc_sample && req_pos_x[hbs_pkg::POS_W-1] |-> ##(hbs_pkg::LATENCY) rsp_outside_map)
      else $error("negative position not flagged outside");

endmodule

bind heightmap_bilinear_sample hbs_checker u_hbs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .req_pos_x       (req_pos_x),
   .rsp_valid       (rsp_valid),
   .rsp_height      (rsp_height),
   .rsp_outside_map (rsp_outside_map)
);

[test/tb_heightmap_bilinear_sample.sv]
`timescale 1ns / 1ps

// Self-checking bench for the heightmap bilinear sampler.
// Items go in through the start/busy command port. Results come back on a strobe
// that cannot be held off. A local copy of the map and of the Q8.8 scale predicts
// every sample item at the edge that accepts it, and queues the predicted height
// in accept order. A checker process pops one prediction per strobed result and
// compares the height and the outside flag.
// The map contents are undefined until written, so no in-map sample goes out
// before the bench has written all four corners of its cell.
module tb_heightmap_bilinear_sample;

   localparam int MAP_DIM     = hbs_pkg::MAP_DIM_DEFAULT;
   localparam int POS_W       = hbs_pkg::POS_W;
   localparam int FRAC_W      = hbs_pkg::FRAC_W;
   localparam int CELL_W      = hbs_pkg::CELL_W;
   localparam int SAMPLE_W    = hbs_pkg::SAMPLE_W;
   localparam int SCALE_W     = hbs_pkg::SCALE_W;
   localparam int HEIGHT_W    = hbs_pkg::HEIGHT_W;
   localparam int IDLE_PCT    = 30;
   localparam int DRAIN_LIMIT = 1000;
   localparam int PHASE_ITEMS = 32;

   typedef struct {
      logic [HEIGHT_W-1:0] height;
      logic                outside;
   } height_result_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_action;
   logic signed [POS_W-1:0]    req_pos_x;
   logic signed [POS_W-1:0]    req_pos_z;
   logic [CELL_W-1:0]          req_cell_x;
   logic [CELL_W-1:0]          req_cell_z;
   logic [SAMPLE_W-1:0]        req_cell_value;
   logic                       rsp_valid;
   logic [HEIGHT_W-1:0]        rsp_height;
   logic                       rsp_outside_map;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [SCALE_W-1:0]         csr_wdata;

   // Local copy of the map, with a flag per entry that tells whether it was written
   logic [SAMPLE_W-1:0]        terrain [0:MAP_DIM*MAP_DIM-1];
   bit                         terrain_written [0:MAP_DIM*MAP_DIM-1];
   logic [SCALE_W-1:0]         scale_q88;
   height_result_type          pending_heights [$];
   int                         error_count = 0;
   bit                         idle_on = 1'b1;

   heightmap_bilinear_sample #(
      .MAP_DIM(MAP_DIM)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_pos_x      (req_pos_x),
      .req_pos_z      (req_pos_z),
      .req_cell_x     (req_cell_x),
      .req_cell_z     (req_cell_z),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_height     (rsp_height),
      .rsp_outside_map(rsp_outside_map),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // A coordinate lands in the map when it is not negative and its floored cell
   // still has a neighbor cell on the far side.
   function automatic bit coord_in_map(logic signed [POS_W-1:0] pos);
      return !pos[POS_W-1] && (pos[POS_W-2:FRAC_W] < MAP_DIM - 1);
   endfunction

   // Floor both coordinates, blend the four corners in Q16 and scale down to Q8; an outside position gives zero.
   function automatic height_result_type blend_height(
      logic signed [POS_W-1:0] pos_x,
      logic signed [POS_W-1:0] pos_z);
      height_result_type res;
      logic [CELL_W-1:0] cx, cz, cx1, cz1;
      logic [FRAC_W-1:0] fx, fz;
      logic [63:0]       h11, h12, h21, h22, row0, row1, blend, scaled;
      res.height  = '0;
      res.outside = 1'b1;
      if (coord_in_map(pos_x) && coord_in_map(pos_z)) begin
         cx     = pos_x[FRAC_W +: CELL_W];
         cz     = pos_z[FRAC_W +: CELL_W];
         cx1    = cx + 1'b1;
         cz1    = cz + 1'b1;
         fx     = pos_x[FRAC_W-1:0];
         fz     = pos_z[FRAC_W-1:0];
         h11    = terrain[{cx, cz}];
         h12    = terrain[{cx, cz1}];
         h21    = terrain[{cx1, cz}];
         h22    = terrain[{cx1, cz1}];
         row0   = h11 * (64'd256 - fz) + h12 * fz;
         row1   = h21 * (64'd256 - fz) + h22 * fz;
         blend  = row0 * (64'd256 - fx) + row1 * fx;
         scaled = (blend * scale_q88) >> 16;
         res.height  = scaled[HEIGHT_W-1:0];
         res.outside = 1'b0;
      end
      return res;
   endfunction

   // Present one item, hold it until the block takes it, then update the local
   // map or queue the predicted height. Leave start high so back-to-back items
   // need no second assignment in the same step. While idle_on is set, idle first at random.
   task automatic send_item(hbs_pkg::action_type act, logic signed [POS_W-1:0] pos_x,
                            logic signed [POS_W-1:0] pos_z, logic [CELL_W-1:0] cx,
                            logic [CELL_W-1:0] cz, logic [SAMPLE_W-1:0] value);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_pos_x      <= pos_x;
      req_pos_z      <= pos_z;
      req_cell_x     <= cx;
      req_cell_z     <= cz;
      req_cell_value <= value;
      do @(posedge clock); while (busy);
      if (act == hbs_pkg::ACT_WRITE) begin
         terrain[{cx, cz}]         = value;
         terrain_written[{cx, cz}] = 1'b1;
      end else begin
         pending_heights.push_back(blend_height(pos_x, pos_z));
      end
   endtask

   // Write one map entry; the unused position fields carry noise.
   task automatic write_cell(logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cz,
                             logic [SAMPLE_W-1:0] value);
      send_item(hbs_pkg::ACT_WRITE, POS_W'($urandom), POS_W'($urandom), cx, cz, value);
   endtask

   // Sample a position. Fill in any corner of its cell that was never written
   // first, with a random height.
   task automatic query_height(logic signed [POS_W-1:0] pos_x,
                               logic signed [POS_W-1:0] pos_z);
      logic [CELL_W-1:0] cx, cz;
      if (coord_in_map(pos_x) && coord_in_map(pos_z)) begin
         for (int dx = 0; dx < 2; dx++) begin
            for (int dz = 0; dz < 2; dz++) begin
               cx = pos_x[FRAC_W +: CELL_W] + CELL_W'(dx);
               cz = pos_z[FRAC_W +: CELL_W] + CELL_W'(dz);
               if (!terrain_written[{cx, cz}])
                  write_cell(cx, cz, SAMPLE_W'($urandom));
            end
         end
      end
      send_item(hbs_pkg::ACT_SAMPLE, pos_x, pos_z, CELL_W'($urandom), CELL_W'($urandom),
                SAMPLE_W'($urandom));
   endtask

   // Drop start, wait for every queued height, then let the pipe run dry.
   // Count a result that never shows as a failure and clear it.
   task automatic drain();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (pending_heights.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_heights.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  pending_heights.size());
         error_count += pending_heights.size();
         pending_heights.delete();
      end
      repeat (hbs_pkg::LATENCY + 2) @(posedge clock);
   endtask

   // Change the scale only with nothing in flight.
   task automatic set_height_scale(logic [SCALE_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      scale_q88 = value;
      csr_valid <= 1'b0;
   endtask

   // Checker: take every strobed result at its edge and compare with the oldest
   // prediction.
   always @(posedge clock) begin
      height_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_heights.size() == 0) begin
            $display("%0t: unexpected result height=%0d outside=%0b", $time,
                     rsp_height, rsp_outside_map);
            error_count++;
         end else begin
            want = pending_heights.pop_front();
            if (rsp_height !== want.height) begin
               $display("%0t: height expected %0d actual %0d", $time, want.height,
                        rsp_height);
               error_count++;
            end
            if (rsp_outside_map !== want.outside) begin
               $display("%0t: outside_map expected %0b actual %0b", $time,
                        want.outside, rsp_outside_map);
               error_count++;
            end
         end
      end
   end

   // Cell (0,0) with a diagonal of full and empty corners, default unity scale.
   task automatic test_unity_scale_blend();
      write_cell(8'd0, 8'd0, 8'd255);
      write_cell(8'd0, 8'd1, 8'd0);
      write_cell(8'd1, 8'd0, 8'd0);
      write_cell(8'd1, 8'd1, 8'd255);
      query_height(18'sh00000, 18'sh00000);
      query_height(18'sh00080, 18'sh00080);
      query_height(18'sh000FF, 18'sh00000);
      query_height(18'sh000FF, 18'sh000FF);
   endtask

   // Last full cell, the upper bound on each axis, negative and extreme positions.
   task automatic test_map_bounds();
      write_cell(8'd254, 8'd254, 8'd0);
      write_cell(8'd254, 8'd255, 8'd255);
      write_cell(8'd255, 8'd254, 8'd255);
      write_cell(8'd255, 8'd255, 8'd0);
      query_height(18'sh0FEFF, 18'sh0FEFF);
      query_height(18'sh0FF00, 18'sh00000);
      query_height(18'sh00000, 18'sh0FF00);
      query_height(18'sh10000, 18'sh00000);
      query_height(-18'sd1, 18'sh00000);
      query_height(18'sh00000, -18'sd131072);
      query_height(18'sd131071, 18'sd131071);
   endtask

   // Zero, full-range and least nonzero scale, with the largest possible blended height.
   task automatic test_scale_extremes();
      set_height_scale(16'h0000);
      query_height(18'sh00080, 18'sh00080);
      set_height_scale(16'hFFFF);
      write_cell(8'd0, 8'd1, 8'd255);
      write_cell(8'd1, 8'd0, 8'd255);
      query_height(18'sh00047, 18'sh000B3);
      set_height_scale(16'h0001);
      query_height(18'sh000FF, 18'sh000FF);
   endtask

   // Mostly well-formed traffic: random writes, in-map samples of random cells
   // and fractions, and raw positions that usually fall outside. Change the scale
   // between phases and run one phase without gaps.
   task automatic test_random_traffic();
      logic [SCALE_W-1:0] phase_scale [4];
      int                 sel;
      phase_scale[0] = SCALE_W'($urandom);
      phase_scale[1] = 16'hFFFF;
      phase_scale[2] = SCALE_W'($urandom_range(511));
      phase_scale[3] = hbs_pkg::SCALE_RESET;
      for (int phase = 0; phase < 4; phase++) begin
         set_height_scale(phase_scale[phase]);
         idle_on = (phase != 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sel = $urandom_range(99);
            if (sel < 25)
               write_cell(CELL_W'($urandom), CELL_W'($urandom), SAMPLE_W'($urandom));
            else if (sel < 75)
               query_height({2'b00, CELL_W'($urandom_range(MAP_DIM - 2)),
                             FRAC_W'($urandom)},
                            {2'b00, CELL_W'($urandom_range(MAP_DIM - 2)),
                             FRAC_W'($urandom)});
            else if (sel < 85)
               query_height({2'b00, CELL_W'($urandom_range(MAP_DIM - 2)),
                             FRAC_W'($urandom)}, POS_W'($urandom));
            else
               query_height(POS_W'($urandom), POS_W'($urandom));
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = hbs_pkg::ACT_WRITE;
      req_pos_x      = '0;
      req_pos_z      = '0;
      req_cell_x     = '0;
      req_cell_z     = '0;
      req_cell_value = '0;
      csr_valid      = 1'b0;
      csr_wdata      = '0;
      scale_q88      = hbs_pkg::SCALE_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_unity_scale_blend();
      test_map_bounds();
      test_scale_extremes();
      test_random_traffic();
      drain();

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
